/* sv/positional_deque_engine_unit_defines.svh */
// Assertion macros shared by the RTL.
`ifndef POSITIONAL_DEQUE_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_DEQUE_ENGINE_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define PDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define PDQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/pdq_pkg.sv */
`default_nettype none
package pdq_pkg;

  localparam int DEPTH_DEF = 64;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_INSERT     = 3'd4;
  localparam logic [2:0] KIND_READ       = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [6:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         entry_count;
    logic signed [31:0] read_value;
  } out_word_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic signed [31:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* sv/pdq_cell.sv */
`default_nettype none
module pdq_cell #(
  parameter int AW  = 6,
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire pdq_pkg::cell_ctrl_t ctrl,
  input  wire logic [AW-1:0]      at,
  input  wire logic signed [31:0] prev_q,
  input  wire logic signed [31:0] next_q,
  output logic signed [31:0]      data_q
);

  localparam logic [AW-1:0] MyIdx = AW'(IDX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  // Insert: cells past the gap take their front neighbor, the gap takes the value.
  // Remove: cells from the hole on take their back neighbor.
  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (MyIdx == at) begin
        data_nxt = ctrl.value;
      end else if (MyIdx > at) begin
        data_nxt = prev_q;
      end
    end else if (ctrl.rem) begin
      if (MyIdx >= at) begin
        data_nxt = next_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule
`default_nettype wire

/* sv/positional_deque_engine_unit.sv */
`default_nettype none
// Ordered list of up to DEPTH signed 32-bit words held in a row of shifting
// cells, front at position 0. Every operation (push/pop at either end, insert
// before a position, read at a position) completes on the accepting edge, where
// all cells shift in parallel and the result word is registered, showing on
// out_* the next cycle. One word per cycle sustained; the single output
// register is the only thing that throttles input (in_ready drops while a
// result waits and out_ready is low). Reset clears entry count and out_valid;
// the cells hold no reset value and need no clearing pass.
`include "positional_deque_engine_unit_defines.svh"
module positional_deque_engine_unit #(
  parameter int DEPTH = pdq_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pdq_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pdq_pkg::out_word_t     out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int MW = (CW > 7) ? CW : 7;

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               out_valid_r;
  pdq_pkg::out_word_t out_data_r;

  logic                 in_fire;
  logic                 is_full, is_empty;
  logic [MW-1:0]        pos_ext, cnt_ext;
  logic                 ins_c, rem_c;
  logic [AW-1:0]        at_c;
  logic [1:0]           status_c;
  logic signed [31:0]   rd_c;
  pdq_pkg::cell_ctrl_t  ctrl;
  logic signed [31:0]   cell_q [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_full  = (cnt_r == CW'(DEPTH));
  assign is_empty = (cnt_r == '0);
  assign pos_ext  = MW'(in_data.position);
  assign cnt_ext  = MW'(cnt_r);

  always_comb begin
    ins_c    = 1'b0;
    rem_c    = 1'b0;
    at_c     = '0;
    status_c = pdq_pkg::ST_OK;
    rd_c     = '0;
    cnt_nxt  = cnt_r;
    unique case (in_data.kind)
      pdq_pkg::KIND_PUSH_FRONT, pdq_pkg::KIND_PUSH_BACK: begin
        if (is_full) begin
          status_c = pdq_pkg::ST_FULL;
        end else begin
          ins_c   = 1'b1;
          at_c    = (in_data.kind == pdq_pkg::KIND_PUSH_BACK) ? AW'(cnt_r) : '0;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      pdq_pkg::KIND_POP_FRONT, pdq_pkg::KIND_POP_BACK: begin
        if (is_empty) begin
          status_c = pdq_pkg::ST_EMPTY;
        end else begin
          rem_c   = 1'b1;
          at_c    = (in_data.kind == pdq_pkg::KIND_POP_BACK) ? AW'(cnt_r - CW'(1)) : '0;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      pdq_pkg::KIND_INSERT: begin
        if (is_full) begin
          status_c = pdq_pkg::ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_c = pdq_pkg::ST_RANGE;
        end else begin
          ins_c   = 1'b1;
          at_c    = pos_ext[AW-1:0];
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      pdq_pkg::KIND_READ: begin
        // pos below count implies pos below DEPTH
        if (pos_ext < cnt_ext) begin
          rd_c = cell_q[pos_ext[AW-1:0]];
        end else begin
          status_c = pdq_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctrl.ins   = in_fire && ins_c;
  assign ctrl.rem   = in_fire && rem_c;
  assign ctrl.value = in_data.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = cell_q[i];
    end else begin : g_next
      assign next_w = cell_q[i+1];
    end
    pdq_cell #(
      .AW  (AW),
      .IDX (i)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .at     (at_c),
      .prev_q (prev_w),
      .next_q (next_w),
      .data_q (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.status      <= status_c;
      out_data_r.entry_count <= 7'(cnt_nxt);
      out_data_r.read_value  <= rd_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PDQ_ASSERT(a_cnt_bound, cnt_r <= CW'(DEPTH), "entry count above DEPTH")
  `PDQ_ASSERT(a_fire_result, in_fire |=> out_valid, "accepted word gave no result")
  `PDQ_ASSERT(a_empty_cnt, (out_valid && out_data.status == pdq_pkg::ST_EMPTY)
    |-> out_data.entry_count == '0, "empty status with nonzero count")
  `PDQ_ASSERT(a_full_cnt, (out_valid && out_data.status == pdq_pkg::ST_FULL)
    |-> out_data.entry_count == 7'(DEPTH), "full status with count below DEPTH")
  `PDQ_ASSERT(a_rd_zero, (out_valid && out_data.status != pdq_pkg::ST_OK)
    |-> out_data.read_value == '0, "read data on a failed word")

endmodule
`default_nettype wire
